### src/swq_pkg.sv
package swq_pkg;

   // pool size and key width
   localparam int NUM_PROCS = 32;
   localparam int KEY_BITS  = 32;

   localparam int PROC_BITS = $clog2(NUM_PROCS);
   localparam int LINK_BITS = PROC_BITS + 1;
   localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(NUM_PROCS);

   // port field widths
   localparam int KEY_IN_BITS   = 32;
   localparam int PID_IN_BITS   = 5;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [1:0] KIND_BLOCK  = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_DESC   = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_SCAN     = 11'b000_0000_0010,
      S_RM_DI    = 11'b000_0000_0100,
      S_RM_DX    = 11'b000_0000_1000,
      S_HT       = 11'b000_0001_0000,
      S_EXEC     = 11'b000_0010_0000,
      S_BLK_LINK = 11'b000_0100_0000,
      S_POP_WR   = 11'b000_1000_0000,
      S_WALK     = 11'b001_0000_0000,
      S_UNLINK   = 11'b010_0000_0000,
      S_RESP     = 11'b100_0000_0000
   } state_type;

endpackage

### src/swq_ram.sv
module swq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/semaphore_wait_queue_table_unit.sv
// channel   dir  handshake                payload
// req       in   req_tvalid/req_tready    tuser: kind; tdata: sem_key, proc_id
// rsp       out  rsp_tvalid/rsp_tready    tuser: status; tdata: proc_out
//
// one word at a time; block, pop and query scan the key table one entry a cycle
// through a single comparator
// remove walks the waiter links, one link a cycle
// reset (synchronous) frees every descriptor and unblocks every process at once
// a result waits in the output register; the next word is taken meanwhile,
// only the following result stalls until rsp_tready
module semaphore_wait_queue_table_unit
   import swq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // sem_key[31:0], proc_id[36:32], zero pad
   input  logic [1:0]               req_tuser,  // kind[1:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // proc_out[4:0], zero pad
   output logic [1:0]               rsp_tuser   // status[1:0]
);

   state_type state_ff, state_in;

   logic [1:0]           kind_ff, kind_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [PROC_BITS-1:0] pid_ff, pid_in;
   logic [PROC_BITS-1:0] desc_ff, desc_in;
   logic                 new_ff, new_in;

   logic [NUM_PROCS-1:0] desc_in_use_ff, desc_in_use_in;
   logic [NUM_PROCS-1:0] proc_blocked_ff, proc_blocked_in;

   logic [PROC_BITS:0]   scan_addr_ff, scan_addr_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [PROC_BITS-1:0] cmp_idx_ff, cmp_idx_in;
   logic                 free_vld_ff, free_vld_in;
   logic [PROC_BITS-1:0] free_idx_ff, free_idx_in;

   logic [LINK_BITS-1:0] cur_ff, cur_in;
   logic [LINK_BITS-1:0] prev_ff, prev_in;
   logic [LINK_BITS-1:0] tail_ff, tail_in;
   logic                 first_ff, first_in;

   logic [1:0]           res_status_ff, res_status_in;
   logic [PROC_BITS-1:0] res_proc_ff, res_proc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [PID_IN_BITS-1:0] rsp_proc_ff, rsp_proc_in;

   // table ports
   logic                 key_we;
   logic [PROC_BITS-1:0] key_wa;
   logic [KEY_BITS-1:0]  key_rd;
   logic                 head_we, tail_we, link_we, didx_we;
   logic [PROC_BITS-1:0] head_wa, tail_wa, link_wa, didx_wa;
   logic [LINK_BITS-1:0] head_wd, tail_wd, link_wd;
   logic [LINK_BITS-1:0] head_rd, tail_rd, link_rd;
   logic [PROC_BITS-1:0] link_ra;
   logic [PROC_BITS-1:0] didx_rd;

   logic [PID_IN_BITS-1:0] req_pid;
   logic [PROC_BITS-1:0]   req_pid_n;
   logic                   req_pid_ok;
   logic                   req_acc;
   logic                   hit;
   logic                   scan_last;
   logic [LINK_BITS-1:0]   head_v, tail_v, cur_w, pid_link;
   logic                   rsp_load;

   swq_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_PROCS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_ff),
      .rd_addr(scan_addr_ff[PROC_BITS-1:0]), .rd_data(key_rd)
   );

   swq_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_PROCS)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(desc_ff), .rd_data(head_rd)
   );

   swq_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_PROCS)) u_tail_ram (
      .clock(clock), .wr_en(tail_we), .wr_addr(tail_wa), .wr_data(tail_wd),
      .rd_addr(desc_ff), .rd_data(tail_rd)
   );

   swq_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_PROCS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(link_ra), .rd_data(link_rd)
   );

   swq_ram #(.WIDTH(PROC_BITS), .DEPTH(NUM_PROCS)) u_didx_ram (
      .clock(clock), .wr_en(didx_we), .wr_addr(didx_wa), .wr_data(desc_ff),
      .rd_addr(pid_ff), .rd_data(didx_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_pid    = req_tdata[KEY_IN_BITS +: PID_IN_BITS];
   assign req_pid_n  = PROC_BITS'(req_pid);
   assign req_pid_ok = 32'(req_pid) < 32'(NUM_PROCS);

   assign hit       = cmp_vld_ff && desc_in_use_ff[cmp_idx_ff] && (key_rd == key_ff);
   assign scan_last = cmp_vld_ff && (cmp_idx_ff == PROC_BITS'(NUM_PROCS - 1));
   assign head_v    = new_ff ? NIL_LINK : head_rd;
   assign tail_v    = new_ff ? NIL_LINK : tail_rd;
   assign cur_w     = first_ff ? cur_ff : link_rd;
   assign pid_link  = {1'b0, pid_ff};
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      key_in          = key_ff;
      pid_in          = pid_ff;
      desc_in         = desc_ff;
      new_in          = new_ff;
      desc_in_use_in  = desc_in_use_ff;
      proc_blocked_in = proc_blocked_ff;
      scan_addr_in    = scan_addr_ff;
      cmp_vld_in      = cmp_vld_ff;
      cmp_idx_in      = cmp_idx_ff;
      free_vld_in     = free_vld_ff;
      free_idx_in     = free_idx_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      tail_in         = tail_ff;
      first_in        = first_ff;
      res_status_in   = res_status_ff;
      res_proc_in     = res_proc_ff;
      key_we  = 1'b0;
      key_wa  = desc_ff;
      head_we = 1'b0;
      head_wa = desc_ff;
      head_wd = pid_link;
      tail_we = 1'b0;
      tail_wa = desc_ff;
      tail_wd = pid_link;
      link_we = 1'b0;
      link_wa = pid_ff;
      link_wd = NIL_LINK;
      link_ra = cur_w[PROC_BITS-1:0];
      didx_we = 1'b0;
      didx_wa = pid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               kind_in      = req_tuser;
               key_in       = KEY_BITS'(64'(req_tdata[KEY_IN_BITS-1:0]));
               pid_in       = req_pid_n;
               new_in       = 1'b0;
               scan_addr_in = '0;
               cmp_vld_in   = 1'b0;
               free_vld_in  = 1'b0;
               res_status_in = STATUS_NOT_FOUND;
               res_proc_in   = '0;
               case (req_tuser)
                  KIND_BLOCK: begin
                     if (req_pid_ok && !proc_blocked_ff[req_pid_n]) begin
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  KIND_REMOVE: begin
                     if (req_pid_ok && proc_blocked_ff[req_pid_n]) begin
                        state_in = S_RM_DI;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (scan_addr_ff != (PROC_BITS + 1)'(NUM_PROCS)) begin
               scan_addr_in = scan_addr_ff + (PROC_BITS + 1)'(1);
               cmp_vld_in   = 1'b1;
               cmp_idx_in   = scan_addr_ff[PROC_BITS-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff && !desc_in_use_ff[cmp_idx_ff] && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (hit) begin
               desc_in  = cmp_idx_ff;
               state_in = S_HT;
            end else if (scan_last) begin
               // no descriptor holds the key
               if (kind_ff != KIND_BLOCK) begin
                  state_in = S_RESP;
               end else if (free_vld_ff || !desc_in_use_ff[cmp_idx_ff]) begin
                  desc_in  = free_vld_ff ? free_idx_ff : cmp_idx_ff;
                  new_in   = 1'b1;
                  state_in = S_HT;
               end else begin
                  res_status_in = STATUS_NO_DESC;
                  state_in      = S_RESP;
               end
            end
         end

         S_RM_DI: begin
            state_in = S_RM_DX;
         end

         S_RM_DX: begin
            desc_in  = didx_rd;
            state_in = S_HT;
         end

         S_HT: begin
            state_in = S_EXEC;
         end

         S_EXEC: begin
            tail_in = tail_v;
            case (kind_ff)
               KIND_BLOCK: begin
                  desc_in_use_in[desc_ff] = 1'b1;
                  proc_blocked_in[pid_ff] = 1'b1;
                  key_we  = 1'b1;
                  link_we = 1'b1;
                  didx_we = 1'b1;
                  tail_we = 1'b1;
                  head_we = (head_v == NIL_LINK);
                  res_status_in = STATUS_OK;
                  res_proc_in   = pid_ff;
                  if (head_v != NIL_LINK && tail_v != NIL_LINK) begin
                     state_in = S_BLK_LINK;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               KIND_POP: begin
                  if (head_v == NIL_LINK) begin
                     // present but empty: free it
                     desc_in_use_in[desc_ff] = 1'b0;
                     state_in = S_RESP;
                  end else begin
                     cur_in   = head_v;
                     link_ra  = head_v[PROC_BITS-1:0];
                     state_in = S_POP_WR;
                  end
               end
               KIND_REMOVE: begin
                  cur_in   = head_v;
                  prev_in  = NIL_LINK;
                  first_in = 1'b1;
                  state_in = S_WALK;
               end
               default: begin
                  if (head_v != NIL_LINK) begin
                     res_status_in = STATUS_OK;
                     res_proc_in   = head_v[PROC_BITS-1:0];
                  end
                  state_in = S_RESP;
               end
            endcase
         end

         S_BLK_LINK: begin
            link_we  = 1'b1;
            link_wa  = tail_ff[PROC_BITS-1:0];
            link_wd  = pid_link;
            state_in = S_RESP;
         end

         S_POP_WR: begin
            head_we = 1'b1;
            head_wd = link_rd;
            if (link_rd == NIL_LINK) begin
               tail_we = 1'b1;
               tail_wd = NIL_LINK;
               desc_in_use_in[desc_ff] = 1'b0;
            end
            proc_blocked_in[cur_ff[PROC_BITS-1:0]] = 1'b0;
            res_status_in = STATUS_OK;
            res_proc_in   = cur_ff[PROC_BITS-1:0];
            state_in      = S_RESP;
         end

         S_WALK: begin
            first_in = 1'b0;
            if (cur_w == NIL_LINK) begin
               proc_blocked_in[pid_ff] = 1'b0;
               res_status_in = STATUS_OK;
               res_proc_in   = pid_ff;
               state_in      = S_RESP;
            end else if (cur_w == pid_link) begin
               // link read of the process itself is in flight
               state_in = S_UNLINK;
            end else begin
               prev_in = cur_w;
            end
         end

         S_UNLINK: begin
            if (prev_ff == NIL_LINK) begin
               head_we = 1'b1;
               head_wd = link_rd;
            end else begin
               link_we = 1'b1;
               link_wa = prev_ff[PROC_BITS-1:0];
               link_wd = link_rd;
            end
            if (tail_ff == pid_link) begin
               tail_we = 1'b1;
               tail_wd = prev_ff;
            end
            proc_blocked_in[pid_ff] = 1'b0;
            res_status_in = STATUS_OK;
            res_proc_in   = pid_ff;
            state_in      = S_RESP;
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_proc_in   = rsp_proc_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_proc_in   = PID_IN_BITS'(res_proc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         desc_in_use_ff  <= '0;
         proc_blocked_ff <= '0;
         scan_addr_ff    <= '0;
         cmp_vld_ff      <= 1'b0;
         free_vld_ff     <= 1'b0;
         first_ff        <= 1'b0;
         new_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         desc_in_use_ff  <= desc_in_use_in;
         proc_blocked_ff <= proc_blocked_in;
         scan_addr_ff    <= scan_addr_in;
         cmp_vld_ff      <= cmp_vld_in;
         free_vld_ff     <= free_vld_in;
         first_ff        <= first_in;
         new_ff          <= new_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pid_ff        <= pid_in;
      desc_ff       <= desc_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      tail_ff       <= tail_in;
      res_status_ff <= res_status_in;
      res_proc_ff   <= res_proc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_proc_ff   <= rsp_proc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_proc_ff);

   // descriptors change hands only while a word is applied to the tables
   a_in_use_stable: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_EXEC || state_ff == S_POP_WR) |=> $stable(desc_in_use_ff))
      else $error("descriptor in-use bits changed outside an update step");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_RESP)
      else $error("result word raised without passing the response step");

   a_fail_zero_proc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("failed result carries a process number");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_addr_ff <= (PROC_BITS + 1)'(NUM_PROCS))
      else $error("key scan ran past the table");

   a_unlink_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UNLINK |=> !proc_blocked_ff[pid_ff])
      else $error("removed process still marked blocked");

endmodule

### verif/tb_top.sv
module tb_top;
   import swq_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 60;
   localparam int RANDOM_CHUNKS = 8;
   localparam int CHUNK_WORDS   = 80;
   localparam int POOL_MAX      = 8;

   localparam logic [KEY_IN_BITS-1:0] KEY_ZERO = '0;
   localparam logic [KEY_IN_BITS-1:0] KEY_ONES = '1;
   localparam logic [KEY_IN_BITS-1:0] KEY_MID  = 32'h5A5A_A5A5;
   localparam logic [KEY_IN_BITS-1:0] KEY_LATE = 32'h0000_1234;

   typedef struct packed {
      logic [1:0]           status;
      logic [PID_IN_BITS-1:0] proc_out;
   } sem_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // sem_key[31:0], proc_id[36:32], zero pad
   logic [1:0]               req_tuser = '0;  // kind[1:0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // proc_out[4:0], zero pad
   logic [1:0]               rsp_tuser;       // status[1:0]

   semaphore_wait_queue_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // shadow of the descriptor pool and the per-process links
   bit                 sem_busy   [NUM_PROCS];
   bit [KEY_BITS-1:0]  sem_key    [NUM_PROCS];
   bit [LINK_BITS-1:0] sem_head   [NUM_PROCS];
   bit [LINK_BITS-1:0] sem_tail   [NUM_PROCS];
   bit [LINK_BITS-1:0] proc_next  [NUM_PROCS];
   bit [PROC_BITS-1:0] proc_sem   [NUM_PROCS];
   bit                 proc_waits [NUM_PROCS];

   sem_result_type           sem_results_due[$];
   logic [KEY_IN_BITS-1:0]   keys_blocked_on[$];
   logic [KEY_IN_BITS-1:0]   key_pool [POOL_MAX];
   int unsigned              pool_used = 1;

   bit          req_gaps_on   = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   bit          hold_request  = 1'b0;
   bit          hold_taken    = 1'b0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_wait_left = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;

   function automatic void clear_sem_table();
      for (int i = 0; i < NUM_PROCS; i++) begin
         sem_busy[i]   = 1'b0;
         sem_key[i]    = '0;
         sem_head[i]   = NIL_LINK;
         sem_tail[i]   = NIL_LINK;
         proc_next[i]  = NIL_LINK;
         proc_sem[i]   = '0;
         proc_waits[i] = 1'b0;
      end
   endfunction

   function automatic int find_sem(logic [KEY_BITS-1:0] key);
      for (int d = 0; d < NUM_PROCS; d++)
         if (sem_busy[d] && sem_key[d] == key) return d;
      return -1;
   endfunction

   // applies one request to the shadow table and returns its result
   function automatic sem_result_type sem_apply(logic [1:0] kind,
                                                logic [KEY_IN_BITS-1:0] key,
                                                logic [PID_IN_BITS-1:0] pid);
      sem_result_type     r;
      int                 d;
      logic [LINK_BITS-1:0] h, prev, cur, nxt;
      r.status   = STATUS_NOT_FOUND;
      r.proc_out = '0;
      case (kind)
         KIND_BLOCK: begin
            if (!proc_waits[pid]) begin
               d = find_sem(key[KEY_BITS-1:0]);
               if (d < 0) begin
                  for (int i = NUM_PROCS - 1; i >= 0; i--)
                     if (!sem_busy[i]) d = i;
                  if (d >= 0) begin
                     sem_busy[d] = 1'b1;
                     sem_key[d]  = key[KEY_BITS-1:0];
                     sem_head[d] = NIL_LINK;
                     sem_tail[d] = NIL_LINK;
                  end
               end
               if (d < 0) begin
                  r.status = STATUS_NO_DESC;
               end else begin
                  proc_next[pid]  = NIL_LINK;
                  proc_sem[pid]   = d[PROC_BITS-1:0];
                  proc_waits[pid] = 1'b1;
                  if (sem_head[d] == NIL_LINK)
                     sem_head[d] = LINK_BITS'(pid);
                  else if (sem_tail[d] != NIL_LINK)
                     proc_next[sem_tail[d][PROC_BITS-1:0]] = LINK_BITS'(pid);
                  sem_tail[d] = LINK_BITS'(pid);
                  r.status    = STATUS_OK;
                  r.proc_out  = pid;
               end
            end
         end
         KIND_POP: begin
            d = find_sem(key[KEY_BITS-1:0]);
            if (d >= 0) begin
               h = sem_head[d];
               if (h != NIL_LINK) begin
                  sem_head[d] = proc_next[h[PROC_BITS-1:0]];
                  if (sem_head[d] == NIL_LINK) sem_tail[d] = NIL_LINK;
                  proc_next[h[PROC_BITS-1:0]]  = NIL_LINK;
                  proc_waits[h[PROC_BITS-1:0]] = 1'b0;
                  r.status   = STATUS_OK;
                  r.proc_out = h[PROC_BITS-1:0];
               end
               // a drained or already empty queue releases its descriptor
               if (sem_head[d] == NIL_LINK) sem_busy[d] = 1'b0;
            end
         end
         KIND_REMOVE: begin
            if (proc_waits[pid]) begin
               d    = proc_sem[pid];
               prev = NIL_LINK;
               cur  = sem_head[d];
               for (int g = 0; g < NUM_PROCS && cur != NIL_LINK; g++) begin
                  if (cur == LINK_BITS'(pid)) begin
                     nxt = proc_next[cur[PROC_BITS-1:0]];
                     if (prev == NIL_LINK) sem_head[d] = nxt;
                     else proc_next[prev[PROC_BITS-1:0]] = nxt;
                     if (sem_tail[d] == LINK_BITS'(pid)) sem_tail[d] = prev;
                     break;
                  end
                  prev = cur;
                  cur  = proc_next[cur[PROC_BITS-1:0]];
               end
               proc_next[pid]  = NIL_LINK;
               proc_waits[pid] = 1'b0;
               r.status   = STATUS_OK;
               r.proc_out = pid;
            end
         end
         default: begin
            d = find_sem(key[KEY_BITS-1:0]);
            if (d >= 0 && sem_head[d] != NIL_LINK) begin
               r.status   = STATUS_OK;
               r.proc_out = sem_head[d][PROC_BITS-1:0];
            end
         end
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [KEY_IN_BITS-1:0] key,
                               input logic [PID_IN_BITS-1:0] pid);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_BITS'({pid, key});
      do @(posedge clock); while (!req_tready);
      sem_results_due.push_back(sem_apply(kind, key, pid));
      if (kind == KIND_BLOCK) keys_blocked_on.push_back(key);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // well-formed traffic over a small key pool, with some stray keys and pids
   task automatic send_random_request();
      logic [1:0]             kind;
      logic [KEY_IN_BITS-1:0] key;
      logic [PID_IN_BITS-1:0] pid;
      int unsigned            w, r;
      w   = $urandom_range(0, 99);
      r   = $urandom_range(0, 99);
      pid = PID_IN_BITS'($urandom);
      key = $urandom;
      if (w < 40) begin
         kind = KIND_BLOCK;
         if (r < 85) key = key_pool[$urandom_range(0, pool_used - 1)];
      end else if (w < 85 && w >= 65) begin
         kind = KIND_REMOVE;
         // usually aim at a process that is actually waiting
         if (r < 70) begin
            for (int i = 0; i < NUM_PROCS; i++)
               if (proc_waits[PID_IN_BITS'(pid + i)]) begin
                  pid = PID_IN_BITS'(pid + i);
                  break;
               end
         end
      end else begin
         kind = (w < 65) ? KIND_POP : KIND_QUERY;
         if (r < 60)
            key = key_pool[$urandom_range(0, pool_used - 1)];
         else if (r < 90 && keys_blocked_on.size() != 0)
            key = keys_blocked_on[$urandom_range(0, keys_blocked_on.size() - 1)];
      end
      send_request(kind, key, pid);
   endtask

   task automatic test_basic_ops();
      send_request(KIND_QUERY, KEY_ZERO, 5'd9);
      send_request(KIND_POP, KEY_ZERO, 5'd9);
      send_request(KIND_BLOCK, KEY_ZERO, 5'd0);
      send_request(KIND_BLOCK, KEY_ONES, 5'd31);
      send_request(KIND_BLOCK, KEY_ZERO, 5'd1);
      // process already waiting elsewhere
      send_request(KIND_BLOCK, KEY_MID, 5'd0);
      send_request(KIND_QUERY, KEY_ZERO, 5'd17);
      send_request(KIND_BLOCK, KEY_ZERO, 5'd2);
      send_request(KIND_REMOVE, $urandom, 5'd1);
      send_request(KIND_POP, KEY_ZERO, 5'd31);
      send_request(KIND_POP, KEY_ZERO, 5'd0);
      send_request(KIND_POP, KEY_ZERO, 5'd0);
      send_request(KIND_QUERY, KEY_ONES, 5'd0);
      // removing the only waiter leaves an empty descriptor behind
      send_request(KIND_REMOVE, $urandom, 5'd31);
      send_request(KIND_QUERY, KEY_ONES, 5'd31);
      send_request(KIND_REMOVE, $urandom, 5'd31);
      send_request(KIND_BLOCK, KEY_ONES, 5'd5);
      send_request(KIND_REMOVE, $urandom, 5'd5);
      send_request(KIND_POP, KEY_ONES, 5'd5);
      send_request(KIND_QUERY, KEY_ONES, 5'd5);
      // tail removal then append must relink the tail
      send_request(KIND_BLOCK, KEY_MID, 5'd3);
      send_request(KIND_BLOCK, KEY_MID, 5'd4);
      send_request(KIND_REMOVE, $urandom, 5'd4);
      send_request(KIND_BLOCK, KEY_MID, 5'd6);
      send_request(KIND_POP, KEY_MID, 5'd3);
      send_request(KIND_POP, KEY_MID, 5'd6);
   endtask

   task automatic test_table_full();
      logic [KEY_IN_BITS-1:0] full_keys [NUM_PROCS];
      for (int i = 0; i < NUM_PROCS; i++) begin
         full_keys[i] = {3'b101, i[4:0], 24'($urandom)};
         send_request(KIND_BLOCK, full_keys[i], PID_IN_BITS'(i));
      end
      send_request(KIND_REMOVE, $urandom, 5'd7);
      send_request(KIND_BLOCK, KEY_LATE, 5'd7);
      send_request(KIND_QUERY, full_keys[7], 5'd7);
      send_request(KIND_POP, full_keys[7], 5'd7);
      send_request(KIND_BLOCK, KEY_LATE, 5'd7);
      for (int i = 0; i < NUM_PROCS; i++)
         send_request(KIND_POP, full_keys[i], PID_IN_BITS'($urandom));
      send_request(KIND_POP, KEY_LATE, 5'd0);
   endtask

   // receiver freezes while the sender keeps offering words back to back
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      pool_used    = 3;
      key_pool[0]  = KEY_MID;
      key_pool[1]  = KEY_ZERO;
      key_pool[2]  = $urandom;
      hold_request <= 1'b1;
      repeat (16) send_random_request();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned r;
      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         pool_used = $urandom_range(1, POOL_MAX);
         for (int i = 0; i < POOL_MAX; i++) begin
            r = $urandom_range(0, 5);
            key_pool[i] = (r == 0) ? KEY_ZERO : (r == 1) ? KEY_ONES : $urandom;
         end
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         repeat (CHUNK_WORDS) send_random_request();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   always @(posedge clock) begin : rsp_ready_drive
      int unsigned stall_n;
      if (hold_request && !hold_taken) begin
         hold_taken    <= 1'b1;
         rsp_hold_left <= HOLD_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (rsp_wait_left != 0) begin
         rsp_wait_left <= rsp_wait_left - 1;
         rsp_tready    <= 1'b0;
      end else begin
         stall_n = rsp_stalls_on ? pick_gap() : 0;
         if (stall_n == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready    <= 1'b0;
            rsp_wait_left <= stall_n - 1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sem_result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sem_results_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("result word with nothing pending: status %0d tdata %h",
                        rsp_tuser, rsp_tdata);
         end else begin
            due = sem_results_due.pop_front();
            if (rsp_tuser !== due.status ||
                rsp_tdata !== RSP_DATA_BITS'(due.proc_out)) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: status %0d proc %0d, got status %0d tdata %h",
                           due.status, due.proc_out, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clear_sem_table();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_table_full();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (sem_results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
